// ===== hdl/sfr_pkg.sv =====
// Shared types and constants for the serial radio control frame receiver.
package sfr_pkg;

   localparam int BUFFER_BYTES = 26;
   localparam int POS_W = 5;
   localparam int CHAN_BITS = 11;
   localparam int CHANNEL_COUNT = 16;
   localparam int PAYLOAD_BYTES = 22;
   localparam int PAYLOAD_W = PAYLOAD_BYTES * 8;
   localparam int INDEX_W = 5;

   localparam logic [7:0] START_BYTE = 8'h0F;
   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam logic [7:0] GAP_MIN_RESET = 8'd3;
   localparam logic [7:0] IDLE_MAX = 8'hFF;
   localparam logic [POS_W-1:0] FLAGS_POSITION = POS_W'(23);
   localparam logic [POS_W-1:0] END_POSITION = POS_W'(24);

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_TICK    = 2'd1,
      OP_PROCESS = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef struct packed {
      logic               byte_we;
      logic               tick;
      logic               load_first;
      logic               load_chan;
      logic               clear;
      logic [INDEX_W-1:0] chan_index;
      logic               chan_last;
   } cmd_type;

   typedef struct packed {
      logic frame_ok;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/sbus_frame_receiver.sv =====
// Top level of the 16-channel serial radio control frame receiver.
// A byte, tick or unused-op transaction is accepted and gives no result.
// A process transaction puts its first result in the output register in the next cycle.
// A good frame then gives one channel per cycle, 17 results in all, paced by rsp_ready.
// New requests wait until the last result of a process is leaving the output register.
// Synchronous reset opens no frame, fills the buffer with 0xFF and sets gap_min to 3.
module sbus_frame_receiver #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_byte_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_rejected,
   output logic                        rsp_bad_start,
   output logic                        rsp_bad_end,
   output logic                        rsp_bad_length,
   output logic [sfr_pkg::INDEX_W-1:0] rsp_channel_index,
   output logic [10:0]                 rsp_chan_value,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [7:0]                  csr_gap_min
);

   sfr_pkg::cmd_type    cmd;
   sfr_pkg::status_type status;

   assign csr_ready = 1'b1;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   sfr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .byte_value        (req_byte_value),
      .csr_we            (csr_valid && csr_ready),
      .csr_data          (csr_gap_min),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rejected      (rsp_rejected),
      .rsp_bad_start     (rsp_bad_start),
      .rsp_bad_end       (rsp_bad_end),
      .rsp_bad_length    (rsp_bad_length),
      .rsp_channel_index (rsp_channel_index),
      .rsp_chan_value    (rsp_chan_value),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== hdl/sfr_datapath.sv =====
// Frame buffer, idle counter, frame checks and result register of the receiver.
module sfr_datapath #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::cmd_type            cmd,
   output sfr_pkg::status_type         status,
   input  logic [7:0]                  byte_value,
   input  logic                        csr_we,
   input  logic [7:0]                  csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_rejected,
   output logic                        rsp_bad_start,
   output logic                        rsp_bad_end,
   output logic                        rsp_bad_length,
   output logic [sfr_pkg::INDEX_W-1:0] rsp_channel_index,
   output logic [10:0]                 rsp_chan_value,
   output logic                        rsp_last
);

   localparam int FRAME_W = BUFFER_BYTES * 8;
   localparam int POS_W = sfr_pkg::POS_W;
   localparam int CB = sfr_pkg::CHAN_BITS;
   localparam int PW = sfr_pkg::PAYLOAD_W;

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               open_ff, open_in;
   logic [7:0]         idle_ff, idle_in;
   logic [7:0]         gap_ff, gap_in;

   logic               valid_ff, valid_in;
   logic               rej_ff, rej_in;
   logic               bs_ff, bs_in;
   logic               be_ff, be_in;
   logic               bl_ff, bl_in;
   logic [sfr_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [10:0]        val_ff, val_in;
   logic               last_ff, last_in;

   logic [7:0] byte0, byte23, byte24;
   logic       bad_start, bad_end, bad_length, out_free, is_start;

   assign byte0 = frame_ff[7:0];
   assign byte23 = frame_ff[8*int'(sfr_pkg::FLAGS_POSITION) +: 8];
   assign byte24 = frame_ff[8*int'(sfr_pkg::END_POSITION) +: 8];
   assign bad_start = byte0 != sfr_pkg::START_BYTE;
   assign bad_end = byte24 != 8'd0;
   assign bad_length = !(open_ff && pos_ff == sfr_pkg::END_POSITION);
   assign out_free = !valid_ff || rsp_ready;
   assign is_start = byte_value == sfr_pkg::START_BYTE && idle_ff > gap_ff;

   assign status.frame_ok = !bad_start && !bad_end && !bad_length;
   assign status.out_free = out_free;

   always_comb begin
      frame_in = frame_ff;
      pos_in = pos_ff;
      open_in = open_ff;
      idle_in = idle_ff;
      gap_in = csr_we ? csr_data : gap_ff;
      valid_in = valid_ff && !rsp_ready;
      rej_in = rej_ff;
      bs_in = bs_ff;
      be_in = be_ff;
      bl_in = bl_ff;
      idx_in = idx_ff;
      val_in = val_ff;
      last_in = last_ff;

      if (cmd.byte_we) begin
         idle_in = 8'd0;
         if (is_start) begin
            pos_in = '0;
            open_in = 1'b1;
            frame_in[7:0] = byte_value;
         end else if (open_ff && pos_ff == sfr_pkg::END_POSITION) begin
            frame_in[8*int'(sfr_pkg::END_POSITION) +: 8] = sfr_pkg::FILL_BYTE;
         end else if (open_ff) begin
            pos_in = pos_ff + POS_W'(1);
            for (int i = 0; i < BUFFER_BYTES; i++) begin
               if (pos_in == POS_W'(i)) begin
                  frame_in[8*i +: 8] = byte_value;
               end
            end
         end
      end

      if (cmd.tick && idle_ff != sfr_pkg::IDLE_MAX) begin
         idle_in = idle_ff + 8'd1;
      end

      if (cmd.load_first) begin
         valid_in = 1'b1;
         idx_in = '0;
         if (status.frame_ok) begin
            rej_in = 1'b0;
            bs_in = 1'b0;
            be_in = 1'b0;
            bl_in = 1'b0;
            val_in = {3'b000, byte23};
            last_in = 1'b0;
         end else begin
            rej_in = 1'b1;
            bs_in = bad_start;
            be_in = bad_end;
            bl_in = bad_length;
            val_in = '0;
            last_in = 1'b1;
         end
      end

      if (cmd.load_chan) begin
         valid_in = 1'b1;
         rej_in = 1'b0;
         bs_in = 1'b0;
         be_in = 1'b0;
         bl_in = 1'b0;
         idx_in = cmd.chan_index;
         val_in = frame_ff[8 +: CB];
         last_in = cmd.chan_last;
         frame_in[8 +: PW] = {{CB{1'b1}}, frame_ff[8+CB +: PW-CB]};
      end

      if (cmd.clear) begin
         frame_in = '1;
         pos_in = '0;
         open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '1;
         pos_ff <= '0;
         open_ff <= 1'b0;
         idle_ff <= sfr_pkg::IDLE_MAX;
         gap_ff <= sfr_pkg::GAP_MIN_RESET;
         valid_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         pos_ff <= pos_in;
         open_ff <= open_in;
         idle_ff <= idle_in;
         gap_ff <= gap_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rej_ff <= rej_in;
      bs_ff <= bs_in;
      be_ff <= be_in;
      bl_ff <= bl_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_rejected = rej_ff;
   assign rsp_bad_start = bs_ff;
   assign rsp_bad_end = be_ff;
   assign rsp_bad_length = bl_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_chan_value = val_ff;
   assign rsp_last = last_ff;

endmodule

// ===== hdl/sfr_ctrl.sv =====
// Controller state machine that decodes requests and sequences the channel results.
module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  sfr_pkg::status_type status,
   output sfr_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   localparam int IW = sfr_pkg::INDEX_W;

   state_type        state_ff, state_in;
   logic [IW-1:0]    chan_ff, chan_in;
   logic             accept;
   sfr_pkg::op_type  op;

   assign op = sfr_pkg::op_type'(req_op);
   assign req_ready = state_ff == ST_IDLE && status.out_free;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      chan_in = chan_ff;
      cmd = '0;
      cmd.chan_index = chan_ff;
      cmd.chan_last = chan_ff == IW'(sfr_pkg::CHANNEL_COUNT);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  sfr_pkg::OP_BYTE: cmd.byte_we = 1'b1;
                  sfr_pkg::OP_TICK: cmd.tick = 1'b1;
                  sfr_pkg::OP_PROCESS: begin
                     cmd.load_first = 1'b1;
                     if (status.frame_ok) begin
                        state_in = ST_EMIT;
                        chan_in = IW'(1);
                     end else begin
                        cmd.clear = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_chan = 1'b1;
               chan_in = chan_ff + IW'(1);
               if (cmd.chan_last) begin
                  cmd.clear = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff <= chan_in;
      end
   end

endmodule

// ===== tb/sv/sbus_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the serial radio control frame receiver.
module sbus_frame_receiver_tb;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [2:0] NO_START = 3'b100;
   localparam logic [2:0] NO_END = 3'b010;
   localparam logic [2:0] NO_LENGTH = 3'b001;
   localparam logic [2:0] NO_FLAGS = 3'b000;

   typedef struct packed {
      logic                        rejected;
      logic                        bad_start;
      logic                        bad_end;
      logic                        bad_length;
      logic [sfr_pkg::INDEX_W-1:0] channel_index;
      logic [10:0]                 chan_value;
      logic                        last;
   } rx_word_type;

   typedef struct packed {
      sfr_pkg::op_type op;
      logic [7:0]      value;
      logic [7:0]      count;
      logic            typed;
      logic [2:0]      flags;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 15;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{sfr_pkg::OP_PROCESS, 8'h00, 8'd1, 1'b1, NO_START | NO_END | NO_LENGTH},
      '{sfr_pkg::OP_TICK, 8'h00, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_UNUSED, 8'hFF, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, sfr_pkg::START_BYTE, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, 8'hFF, 8'd22, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, 8'h00, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, 8'h00, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_PROCESS, 8'hFF, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_PROCESS, 8'h00, 8'd1, 1'b1, NO_START | NO_END | NO_LENGTH},
      '{sfr_pkg::OP_TICK, 8'hFF, 8'd3, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, sfr_pkg::START_BYTE, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_TICK, 8'h00, 8'd4, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, sfr_pkg::START_BYTE, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_BYTE, 8'hA5, 8'd1, 1'b0, NO_FLAGS},
      '{sfr_pkg::OP_PROCESS, 8'h00, 8'd1, 1'b1, NO_END | NO_LENGTH}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_op = sfr_pkg::OP_BYTE;
   logic [7:0]                    req_byte_value = 8'h00;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b1;
   logic                          rsp_rejected;
   logic                          rsp_bad_start;
   logic                          rsp_bad_end;
   logic                          rsp_bad_length;
   logic [sfr_pkg::INDEX_W-1:0]   rsp_channel_index;
   logic [10:0]                   rsp_chan_value;
   logic                          rsp_last;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [7:0]                    csr_gap_min = 8'h00;

   logic [7:0]                    frame_buf [sfr_pkg::BUFFER_BYTES];
   logic [sfr_pkg::POS_W-1:0]     wr_pos = '0;
   bit                            frame_open = 1'b0;
   logic [7:0]                    idle_count = sfr_pkg::IDLE_MAX;
   logic [7:0]                    gap_min_model = sfr_pkg::GAP_MIN_RESET;

   rx_word_type          fresh_words [$];
   rx_word_type          words_due [$];
   int                   mismatches = 0;
   int                   quiet_cycles = 0;
   int                   items_sent = 0;
   int                   stall_left = 0;
   bit                   no_idle = 1'b0;
   bit                   calm = 1'b0;

   sbus_frame_receiver i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rejected      (rsp_rejected),
      .rsp_bad_start     (rsp_bad_start),
      .rsp_bad_end       (rsp_bad_end),
      .rsp_bad_length    (rsp_bad_length),
      .rsp_channel_index (rsp_channel_index),
      .rsp_chan_value    (rsp_chan_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_gap_min       (csr_gap_min)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic string word_text(input rx_word_type w);
      return $sformatf("rej %b start %b end %b len %b index %0d value 0x%03h last %b",
                       w.rejected, w.bad_start, w.bad_end, w.bad_length,
                       w.channel_index, w.chan_value, w.last);
   endfunction

   function automatic void track_frame_item(input sfr_pkg::op_type op,
                                            input logic [7:0] value);
      logic [sfr_pkg::PAYLOAD_W-1:0] payload;
      rx_word_type                   w;
      logic                          bs;
      logic                          be;
      logic                          bl;
      fresh_words.delete();
      case (op)
         sfr_pkg::OP_BYTE: begin
            if (value == sfr_pkg::START_BYTE && idle_count > gap_min_model) begin
               wr_pos = '0;
               frame_open = 1'b1;
               frame_buf[0] = value;
            end else if (frame_open && wr_pos == sfr_pkg::END_POSITION) begin
               frame_buf[sfr_pkg::END_POSITION] = sfr_pkg::FILL_BYTE;
            end else if (frame_open) begin
               wr_pos = wr_pos + sfr_pkg::POS_W'(1);
               if (wr_pos < sfr_pkg::BUFFER_BYTES) frame_buf[wr_pos] = value;
            end
            idle_count = '0;
         end
         sfr_pkg::OP_TICK: begin
            if (idle_count != sfr_pkg::IDLE_MAX) idle_count = idle_count + 8'd1;
         end
         sfr_pkg::OP_PROCESS: begin
            bs = (frame_buf[0] != sfr_pkg::START_BYTE);
            be = (frame_buf[sfr_pkg::END_POSITION] != 8'h00);
            bl = !(frame_open && wr_pos == sfr_pkg::END_POSITION);
            w = '0;
            if (!(bs || be || bl)) begin
               for (int k = 0; k < sfr_pkg::PAYLOAD_BYTES; k++)
                  payload[8*k +: 8] = frame_buf[k + 1];
               w.chan_value = {3'b000, frame_buf[sfr_pkg::FLAGS_POSITION]};
               fresh_words.push_back(w);
               for (int ch = 1; ch <= sfr_pkg::CHANNEL_COUNT; ch++) begin
                  w.channel_index = sfr_pkg::INDEX_W'(ch);
                  w.chan_value = payload[sfr_pkg::CHAN_BITS*(ch-1) +: sfr_pkg::CHAN_BITS];
                  w.last = (ch == sfr_pkg::CHANNEL_COUNT);
                  fresh_words.push_back(w);
               end
            end else begin
               w.rejected = 1'b1;
               w.bad_start = bs;
               w.bad_end = be;
               w.bad_length = bl;
               w.last = 1'b1;
               fresh_words.push_back(w);
            end
            foreach (frame_buf[k]) frame_buf[k] = sfr_pkg::FILL_BYTE;
            wr_pos = '0;
            frame_open = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_req(input sfr_pkg::op_type op, input logic [7:0] value,
                           input bit typed, input logic [2:0] flags);
      int          gap;
      rx_word_type w;
      if (!no_idle && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
      else gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_byte_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      track_frame_item(op, value);
      if (typed) begin
         w = '0;
         w.rejected = 1'b1;
         w.bad_start = |(flags & NO_START);
         w.bad_end = |(flags & NO_END);
         w.bad_length = |(flags & NO_LENGTH);
         w.last = 1'b1;
         words_due.push_back(w);
      end else begin
         foreach (fresh_words[k]) words_due.push_back(fresh_words[k]);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_gap_min <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gap_min_model = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int quota);
      int         stop_at;
      int         shape;
      int         mode;
      int         ticks;
      int         body;
      logic [7:0] v;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         calm = ($urandom_range(0, 3) == 0);
         if (gap_min_model > 16 || $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               v = ($urandom_range(0, 3) == 0) ? sfr_pkg::START_BYTE : 8'($urandom);
               send_req(sfr_pkg::op_type'($urandom_range(0, 3)), v, 1'b0, NO_FLAGS);
            end
         end else begin
            shape = $urandom_range(0, 9);
            mode = $urandom_range(0, 5);
            ticks = (shape == 9) ? gap_min_model : gap_min_model + 1 + $urandom_range(0, 2);
            repeat (ticks) send_req(sfr_pkg::OP_TICK, 8'($urandom), 1'b0, NO_FLAGS);
            send_req(sfr_pkg::OP_BYTE, sfr_pkg::START_BYTE, 1'b0, NO_FLAGS);
            body = sfr_pkg::END_POSITION;
            if (shape == 6) body = $urandom_range(0, 23);
            if (shape == 7) body = sfr_pkg::END_POSITION + $urandom_range(1, 3);
            for (int p = 1; p <= body; p++) begin
               case (mode)
                  3: v = 8'h00;
                  4: v = sfr_pkg::FILL_BYTE;
                  5: begin
                     case ($urandom_range(0, 2))
                        0: v = 8'h00;
                        1: v = sfr_pkg::FILL_BYTE;
                        default: v = sfr_pkg::START_BYTE;
                     endcase
                  end
                  default: v = 8'($urandom);
               endcase
               if (p == sfr_pkg::FLAGS_POSITION) v = 8'($urandom);
               if (p == sfr_pkg::END_POSITION)
                  v = (shape == 8) ? 8'($urandom_range(1, 255)) : 8'h00;
               if ($urandom_range(0, 19) == 0)
                  send_req($urandom_range(0, 1) ? sfr_pkg::OP_TICK : sfr_pkg::OP_UNUSED,
                           8'($urandom), 1'b0, NO_FLAGS);
               send_req(sfr_pkg::OP_BYTE, v, 1'b0, NO_FLAGS);
            end
            send_req(sfr_pkg::OP_PROCESS, 8'($urandom), 1'b0, NO_FLAGS);
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (!no_idle && !calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_words
      rx_word_type got;
      rx_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_rejected, rsp_bad_start, rsp_bad_end, rsp_bad_length,
                   rsp_channel_index, rsp_chan_value, rsp_last};
            if (words_due.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("unexpected result: %s", word_text(got));
               mismatches++;
            end else begin
               want = words_due.pop_front();
               if (got !== want) begin
                  if (mismatches < MAX_REPORTS) begin
                     $display("mismatch at %0t", $realtime);
                     $display("   expected %s", word_text(want));
                     $display("   actual   %s", word_text(got));
                  end
                  mismatches++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("sbus_frame_receiver_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      foreach (frame_buf[k]) frame_buf[k] = sfr_pkg::FILL_BYTE;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         for (int n = 0; n < DIRECTED_ROWS[r].count; n++)
            send_req(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                     DIRECTED_ROWS[r].flags);
      end

      settle();
      write_gap(8'd0);
      run_random(40);
      settle();
      write_gap(8'd255);
      run_random(15);
      settle();
      write_gap(8'($urandom_range(1, 6)));
      run_random(40);
      settle();
      write_gap(sfr_pkg::GAP_MIN_RESET);
      no_idle = 1'b1;
      run_random(35);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (words_due.size() != 0)
         $display("%0d channel words never arrived", words_due.size());
      if (mismatches == 0 && words_due.size() == 0)
         $display("sbus_frame_receiver_tb OK");
      else
         $display("sbus_frame_receiver_tb NOT OK");
      $finish;
   end

endmodule
